// ===== rtl/wsmsc_pkg.sv =====
// package: shared constants, command codes and types of the wheel speed controller
`default_nettype none
package wsmsc_pkg;

  localparam int FracBits    = 16;
  localparam int CounterBits = 16;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 32;
  localparam int ProdW       = 64;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSlope   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGain    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSwHigh  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSwLow   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAdapt   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSpc     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPeriod  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegRate    = 3'd7;

  // multiplier post-processing modes
  typedef enum logic [1:0] {
    MulRaw   = 2'd0,  // plain product, saturate to 32 bits
    MulQ     = 2'd1,  // round by FracBits, saturate
    MulSpeed = 2'd2   // round by 32 - FracBits, saturate
  } mul_mode_e;

  // bridge direction codes
  typedef enum logic [1:0] {
    DirOff     = 2'd0,
    DirForward = 2'd1,
    DirReverse = 2'd2
  } drive_dir_e;

  // input word: one control tick
  typedef struct packed {
    logic        [15:0] encoder_count;
    logic signed [31:0] speed_setpoint;
  } tick_word_t;

  // result word
  typedef struct packed {
    logic        [9:0]  pwm_duty;
    logic        [1:0]  drive_direction;
    logic signed [31:0] measured_speed;
    logic signed [31:0] control_value;
  } drive_word_t;

  typedef struct packed {
    logic              start;
    logic signed [32:0] a;
    logic signed [32:0] b;
    mul_mode_e         mode;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] res;
  } mul_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wsmsc_if.sv =====
// interface: valid/ready channel with generic payload
`default_nettype none
interface wsmsc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/wsmsc_mul.sv =====
// bit-serial signed multiplier with rounding and saturation
`default_nettype none
module wsmsc_mul #(
  parameter int FRACTION_BITS = wsmsc_pkg::FracBits
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wsmsc_pkg::mul_req_t    req_i,
  output wsmsc_pkg::mul_rsp_t    rsp_o
);
  localparam int StepW = 6;

  logic                                  busy_q, busy_d;
  logic [StepW-1:0]                      step_q, step_d;
  logic signed [wsmsc_pkg::ProdW-1:0]    acc_q, acc_d;
  logic signed [wsmsc_pkg::ProdW-1:0]    mcand_q, mcand_d;
  logic [32:0]                           mplier_q, mplier_d;
  wsmsc_pkg::mul_mode_e                  mode_q, mode_d;
  logic                                  done_q, done_d;
  logic signed [31:0]                    res_q, res_d;
  logic signed [wsmsc_pkg::ProdW-1:0]    rnd;
  logic signed [wsmsc_pkg::ProdW-1:0]    addend;

  // shift-and-add, one multiplier bit per cycle; top bit carries negative weight
  always_comb begin
    busy_d   = busy_q;
    step_d   = step_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    mode_d   = mode_q;
    done_d   = 1'b0;
    res_d    = res_q;
    rnd      = '0;
    addend   = mplier_q[0] ? mcand_q : '0;
    if (req_i.start) begin
      busy_d   = 1'b1;
      step_d   = '0;
      acc_d    = '0;
      mcand_d  = {{(wsmsc_pkg::ProdW-33){req_i.a[32]}}, req_i.a};
      mplier_d = req_i.b;
      mode_d   = req_i.mode;
    end else if (busy_q) begin
      if (step_q == StepW'(32)) acc_d = acc_q - addend;
      else acc_d = acc_q + addend;
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      step_d   = step_q + StepW'(1);
      if (step_q == StepW'(33)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        case (mode_q)
          wsmsc_pkg::MulQ: begin
            rnd = (acc_q + (64'sd1 <<< (FRACTION_BITS-1))) >>> FRACTION_BITS;
          end
          wsmsc_pkg::MulSpeed: begin
            rnd = (acc_q + (64'sd1 <<< (31-FRACTION_BITS)))
                  >>> (32-FRACTION_BITS);
          end
          default: rnd = acc_q;
        endcase
        res_d = wsmsc_pkg::sat32(rnd);
        acc_d = acc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    mode_q   <= mode_d;
    res_q    <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;
endmodule
`default_nettype wire

// ===== rtl/wheel_sliding_mode_speed_control.sv =====
// Adaptive sliding-mode wheel speed controller, one word per control tick.
// Channels: in_if carries encoder_count and speed_setpoint; out_if carries
//   pwm_duty, drive_direction, measured_speed and control_value.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i write one register per edge; the user
// must write only while idle; the block itself does not enforce this. Each word
// runs through a sequencer that issues eleven products, in turn, to one
// bit-serial multiplier, each result captured before the next issue; the result
// is registered as the sequencer leaves StSum, and the next word can be taken in
// the cycle after that at the earliest.
// One word is worked on at a time; in_if.ready is high while the sequencer idles.
// The result waits in the output register while out_if.ready is low; the next
// word may be accepted and worked through meanwhile, and is held finished in
// the sequencer until the register frees, so the input stalls from then on.
// Reset clears the tracked counts, speed, error, surface, gain and held duty
// and loads the register defaults. No clearing pass is needed.
`default_nettype none
module wheel_sliding_mode_speed_control #(
  parameter int FRACTION_BITS = wsmsc_pkg::FracBits,
  parameter int COUNTER_BITS  = wsmsc_pkg::CounterBits
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  wsmsc_if.sink                                  in_if,
  wsmsc_if.source                                out_if,
  input  wire logic                              cfg_we_i,
  input  wire logic [wsmsc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [wsmsc_pkg::CfgDataW-1:0]    cfg_data_i
);
  typedef enum logic [4:0] {
    StIdle, StSpeed, StSpeedDot, StErrDot, StSlopeErr, StSurf, StG1, StGdot,
    StGstep, StMu, StUeq, StUw, StSum
  } state_e;

  localparam logic signed [31:0] SwLevel  = 32'sd5 <<< FRACTION_BITS;
  localparam logic signed [63:0] ClampLim = 64'sd1000 <<< FRACTION_BITS;
  localparam logic signed [63:0] ClampVal = 64'sd500 <<< FRACTION_BITS;
  localparam logic signed [33:0] Half = 34'sd1 <<< (COUNTER_BITS-1);

  // configuration registers
  logic [30:0] slope_q, gain_q, sw_hi_q, sw_lo_q, period_q;
  logic signed [31:0] adapt_q;
  logic [31:0] spc_q;
  logic [13:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q  <= 31'd1638400;
      gain_q   <= 31'd2293760;
      sw_hi_q  <= 31'd3276800;
      sw_lo_q  <= 31'd3276800;
      adapt_q  <= '0;
      spc_q    <= 32'd24650106;
      period_q <= 31'd3277;
      rate_q   <= 14'd20;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wsmsc_pkg::RegSlope:  slope_q  <= cfg_data_i[30:0];
        wsmsc_pkg::RegGain:   gain_q   <= cfg_data_i[30:0];
        wsmsc_pkg::RegSwHigh: sw_hi_q  <= cfg_data_i[30:0];
        wsmsc_pkg::RegSwLow:  sw_lo_q  <= cfg_data_i[30:0];
        wsmsc_pkg::RegAdapt:  adapt_q  <= cfg_data_i;
        wsmsc_pkg::RegSpc:    spc_q    <= cfg_data_i;
        wsmsc_pkg::RegPeriod: period_q <= cfg_data_i[30:0];
        wsmsc_pkg::RegRate:   rate_q   <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  wsmsc_pkg::mul_req_t req;
  wsmsc_pkg::mul_rsp_t rsp;

  wsmsc_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp)
  );

  state_e state_q;
  logic issued_q;
  logic [15:0] last_cnt_q;
  logic signed [31:0] last_spd_q, last_err_q, surf_q, again_q;
  logic [9:0] held_q;
  logic signed [16:0] delta_q;
  logic signed [31:0] sp_q, spd_q, sdot_q, err_q, edot_q, serr_q, base_q, g1_q, gdot_q;
  logic signed [31:0] mu_q, ueq_q, uw_q;
  logic out_v_q;
  logic [9:0] o_duty_q;
  logic [1:0] o_dir_q;
  logic signed [31:0] o_spd_q, o_ctrl_q;

  logic signed [33:0] dlt;
  logic [15:0] cnt_m;
  logic signed [31:0] r, sd, mag, sum, ctrl;
  logic signed [63:0] sum64;
  logic signed [32:0] ctrl_mag;
  logic [9:0] duty_new;
  logic in_acc, out_free;

  assign out_free    = !out_v_q || out_if.ready;
  assign in_if.ready = (state_q == StIdle);
  assign in_acc      = in_if.valid && in_if.ready;
  assign cnt_m       = in_if.data.encoder_count & 16'((33'd1 << COUNTER_BITS) - 33'd1);
  assign r           = rsp.res;

  // wrapped count difference
  always_comb begin
    dlt = 34'(cnt_m) - 34'(last_cnt_q);
    if (dlt > Half) dlt = dlt - (Half <<< 1);
    else if (dlt < -Half) dlt = dlt + (Half <<< 1);
  end

  assign sd  = wsmsc_pkg::sat32(64'(edot_q) + 64'(serr_q));
  assign mag = (surf_q == 32'sh8000_0000) ? 32'sh7FFF_FFFF :
               (surf_q < 0 ? -surf_q : surf_q);
  assign sum64 = 64'(ueq_q) + 64'(uw_q) +
                 (surf_q > 0 ? 64'(mu_q) : (surf_q < 0 ? -64'(mu_q) : 64'sd0));

  // clamp rule beyond the outer limit
  always_comb begin
    sum = wsmsc_pkg::sat32(sum64);
    if (64'(sum) > ClampLim) ctrl = wsmsc_pkg::sat32(ClampVal);
    else if (64'(sum) < -ClampLim) ctrl = wsmsc_pkg::sat32(-ClampVal);
    else ctrl = sum;
  end

  // duty from the command magnitude
  assign ctrl_mag = (ctrl < 0) ? -33'(ctrl) : 33'(ctrl);
  assign duty_new = 10'(ctrl_mag >>> FRACTION_BITS);

  // multiplier operand selection per step
  always_comb begin
    req = '0;
    req.mode = wsmsc_pkg::MulQ;
    req.start = !issued_q && (state_q != StIdle) && (state_q != StSum);
    case (state_q)
      StSpeed:    begin req.a = 33'(delta_q); req.b = {1'b0, spc_q};
                        req.mode = wsmsc_pkg::MulSpeed; end
      StSpeedDot: begin req.a = 33'(spd_q) - 33'(last_spd_q); req.b = {19'd0, rate_q};
                        req.mode = wsmsc_pkg::MulRaw; end
      StErrDot:   begin req.a = 33'(err_q) - 33'(last_err_q); req.b = {19'd0, rate_q};
                        req.mode = wsmsc_pkg::MulRaw; end
      StSlopeErr: begin req.a = {2'b0, slope_q}; req.b = 33'(err_q); end
      StSurf:     begin req.a = 33'(sd); req.b = {2'b0, period_q}; end
      StG1:       begin req.a = 33'(adapt_q); req.b = 33'(surf_q); end
      StGdot:     begin req.a = (g1_q == 32'sh8000_0000) ? 33'sh7FFF_FFFF : -33'(g1_q);
                        req.b = 33'(base_q); end
      StGstep:    begin req.a = 33'(gdot_q); req.b = {2'b0, period_q}; end
      StMu:       begin req.a = 33'(mag);
                        req.b = {2'b0, (surf_q >= SwLevel) ? sw_hi_q : sw_lo_q}; end
      StUeq:      begin req.a = 33'(again_q); req.b = 33'(base_q); end
      StUw:       begin req.a = {2'b0, gain_q}; req.b = 33'(surf_q); end
      default:    begin req.a = '0; req.b = '0; end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; issued_q <= 1'b0; out_v_q <= 1'b0;
      last_cnt_q <= '0; last_spd_q <= '0; last_err_q <= '0;
      surf_q <= '0; again_q <= '0; held_q <= '0;
    end else begin
      if (rsp.done) issued_q <= 1'b0;
      else if (req.start) issued_q <= 1'b1;
      if (state_q == StSum && out_free) out_v_q <= 1'b1;
      else if (out_if.ready) out_v_q <= 1'b0;
      case (state_q)
        StIdle: if (in_acc) begin
          delta_q <= dlt[16:0]; sp_q <= in_if.data.speed_setpoint;
          last_cnt_q <= cnt_m; state_q <= StSpeed;
        end
        StSpeed: if (rsp.done) begin
          spd_q <= r; err_q <= wsmsc_pkg::sat32(64'(sp_q) - 64'(r)); state_q <= StSpeedDot;
        end
        StSpeedDot: if (rsp.done) begin sdot_q <= r; state_q <= StErrDot; end
        StErrDot: if (rsp.done) begin
          edot_q <= r; last_spd_q <= spd_q; last_err_q <= err_q; state_q <= StSlopeErr;
        end
        StSlopeErr: if (rsp.done) begin
          serr_q <= r; base_q <= wsmsc_pkg::sat32(64'(sdot_q) + 64'(r)); state_q <= StSurf;
        end
        StSurf: if (rsp.done) begin
          surf_q <= wsmsc_pkg::sat32(64'(surf_q) + 64'(r)); state_q <= StG1;
        end
        StG1: if (rsp.done) begin g1_q <= r; state_q <= StGdot; end
        StGdot: if (rsp.done) begin gdot_q <= r; state_q <= StGstep; end
        StGstep: if (rsp.done) begin
          again_q <= wsmsc_pkg::sat32(64'(again_q) + 64'(r)); state_q <= StMu;
        end
        StMu: if (rsp.done) begin mu_q <= r; state_q <= StUeq; end
        StUeq: if (rsp.done) begin ueq_q <= r; state_q <= StUw; end
        StUw: if (rsp.done) begin uw_q <= r; state_q <= StSum; end
        StSum: if (out_free) begin
          o_spd_q <= spd_q; o_ctrl_q <= ctrl; state_q <= StIdle;
          if (ctrl == 0) begin
            o_dir_q <= wsmsc_pkg::DirOff; o_duty_q <= held_q;
          end else begin
            o_dir_q <= (ctrl > 0) ? wsmsc_pkg::DirForward : wsmsc_pkg::DirReverse;
            held_q <= duty_new;
            o_duty_q <= duty_new;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_if.valid                = out_v_q;
  assign out_if.data.pwm_duty        = o_duty_q;
  assign out_if.data.drive_direction = o_dir_q;
  assign out_if.data.measured_speed  = o_spd_q;
  assign out_if.data.control_value   = o_ctrl_q;
endmodule
`default_nettype wire

// ===== rtl/wsmsc_checker.sv =====
// checker: port-level properties of the wheel speed controller, with bind
`default_nettype none
module wsmsc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [9:0]  duty_i,
  input wire logic [1:0]  dir_i,
  input wire logic [31:0] ctrl_i
);
  // direction is one of the three codes
  a_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (dir_i == wsmsc_pkg::DirOff || dir_i == wsmsc_pkg::DirForward ||
                     dir_i == wsmsc_pkg::DirReverse)) else $error("bad direction");
  // zero command means both pins low
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((ctrl_i == 32'd0) == (dir_i == wsmsc_pkg::DirOff)))
    else $error("dir/ctrl mismatch");
  // duty bounded
  a_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> duty_i <= 10'd1000) else $error("duty too high");
  // a word accepted is not followed by another accept next cycle
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("overlapping words");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(ctrl_i))
    else $error("result dropped");
endmodule

bind wheel_sliding_mode_speed_control wsmsc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .duty_i(out_if.data.pwm_duty), .dir_i(out_if.data.drive_direction),
  .ctrl_i(out_if.data.control_value)
);
`default_nettype wire

// ===== dv/tb_wheel_sliding_mode_speed_control.sv =====
// testbench: wheel speed controller checked word by word against an in-bench predictor
`default_nettype none

class drive_scoreboard;
  localparam int Frac = wsmsc_pkg::FracBits;

  // register copies
  longint slope, sgain, sw_high, sw_low, adapt, spc, period, rate;
  // controller state copies
  longint prev_count, prev_speed, prev_error, surf, again, held;
  wsmsc_pkg::drive_word_t expected_q[$];
  int mismatches;

  function new();
    slope = 1638400; sgain = 2293760; sw_high = 3276800; sw_low = 3276800;
    adapt = 0; spc = 24650106; period = 3277; rate = 20;
    prev_count = 0; prev_speed = 0; prev_error = 0; surf = 0; again = 0; held = 0;
    mismatches = 0;
  endfunction

  function longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round half up, then arithmetic shift
  function longint rnd(longint p, int k);
    return (p + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function longint qmul(longint a, longint b);
    return sat(rnd(a * b, Frac));
  endfunction

  function void set_reg(logic [wsmsc_pkg::CfgIdxW-1:0] idx, logic [31:0] d);
    case (idx)
      wsmsc_pkg::RegSlope:  slope   = longint'(d[30:0]);
      wsmsc_pkg::RegGain:   sgain   = longint'(d[30:0]);
      wsmsc_pkg::RegSwHigh: sw_high = longint'(d[30:0]);
      wsmsc_pkg::RegSwLow:  sw_low  = longint'(d[30:0]);
      wsmsc_pkg::RegAdapt:  adapt   = longint'($signed(d));
      wsmsc_pkg::RegSpc:    spc     = longint'(d);
      wsmsc_pkg::RegPeriod: period  = longint'(d[30:0]);
      wsmsc_pkg::RegRate:   rate    = longint'(d[13:0]);
      default: ;
    endcase
  endfunction

  // one control tick of the controller
  function void note_tick(wsmsc_pkg::tick_word_t w);
    longint delta, speed, sdot, err, edot, serr, s_dot, base, g1, gdot;
    longint mag, mu, ud, ueq, uw, sum, lim;
    wsmsc_pkg::drive_word_t r;
    delta = longint'(w.encoder_count) - prev_count;
    if (delta > 32768) delta -= 65536;
    else if (delta < -32768) delta += 65536;
    speed = sat(rnd(delta * spc, 32 - Frac));
    sdot = sat((speed - prev_speed) * rate);
    err = sat(longint'(w.speed_setpoint) - speed);
    edot = sat((err - prev_error) * rate);
    prev_count = longint'(w.encoder_count);
    prev_speed = speed;
    prev_error = err;
    serr = qmul(slope, err);
    s_dot = sat(edot + serr);
    surf = sat(surf + qmul(s_dot, period));
    base = sat(sdot + serr);
    g1 = qmul(adapt, surf);
    gdot = qmul(sat(-g1), base);
    again = sat(again + qmul(gdot, period));
    mag = (surf < 0) ? -surf : surf;
    if (mag > 64'sd2147483647) mag = 64'sd2147483647;
    mu = qmul(mag, (surf >= (64'sd5 <<< Frac)) ? sw_high : sw_low);
    ud = (surf > 0) ? mu : ((surf < 0) ? -mu : 0);
    ueq = qmul(again, base);
    uw = qmul(sgain, surf);
    sum = sat(ueq + uw + ud);
    // clamp rule beyond the outer limit
    lim = 64'sd1000 <<< Frac;
    if (sum > lim) sum = 64'sd500 <<< Frac;
    else if (sum < -lim) sum = -(64'sd500 <<< Frac);
    if (sum == 0) r.drive_direction = wsmsc_pkg::DirOff;
    else if (sum > 0) begin
      r.drive_direction = wsmsc_pkg::DirForward;
      held = (sum >>> Frac) & 10'h3FF;
    end else begin
      r.drive_direction = wsmsc_pkg::DirReverse;
      held = ((-sum) >>> Frac) & 10'h3FF;
    end
    r.pwm_duty = held[9:0];
    r.measured_speed = speed[31:0];
    r.control_value = sum[31:0];
    expected_q.push_back(r);
  endfunction

  function void fail(string what, wsmsc_pkg::drive_word_t e, wsmsc_pkg::drive_word_t a);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: exp duty %0d dir %0d speed %0d ctrl %0d, %s %0d dir %0d speed %0d ctrl %0d",
               what, e.pwm_duty, e.drive_direction, e.measured_speed, e.control_value,
               "got duty", a.pwm_duty, a.drive_direction, a.measured_speed,
               a.control_value);
  endfunction

  function void check_word(wsmsc_pkg::drive_word_t a);
    wsmsc_pkg::drive_word_t e;
    if (expected_q.size() == 0) begin
      e = '0;
      fail("unexpected word", e, a);
      return;
    end
    e = expected_q.pop_front();
    if (a.pwm_duty != e.pwm_duty || a.drive_direction != e.drive_direction ||
        a.measured_speed != e.measured_speed || a.control_value != e.control_value)
      fail("mismatch", e, a);
  endfunction
endclass

module tb_wheel_sliding_mode_speed_control;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [wsmsc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [wsmsc_pkg::CfgDataW-1:0] cfg_data_i;

  wsmsc_if #(.T(wsmsc_pkg::tick_word_t))  in_ch ();
  wsmsc_if #(.T(wsmsc_pkg::drive_word_t)) out_ch ();

  wheel_sliding_mode_speed_control uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  drive_scoreboard sb = new();
  bit quiet;
  bit hold_req;
  int hold_left;
  int stall_left;
  logic [15:0] cur_count;

  // clock
  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // run limit
  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls, one long hold on request
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 3000;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // write enable stays high across a burst of writes; the next task lowers it
  task automatic cfg_write(logic [wsmsc_pkg::CfgIdxW-1:0] idx, logic [31:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
  endtask

  // sender: optional gap, then offer the word until it is taken
  task automatic send_tick(logic [15:0] cnt, logic [31:0] sp);
    wsmsc_pkg::tick_word_t w;
    w.encoder_count = cnt;
    w.speed_setpoint = sp;
    cfg_we_i <= 1'b0;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_tick(w);
    cur_count = cnt;
  endtask

  task automatic drain();
    cfg_we_i <= 1'b0;
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // mostly plausible speed steps, sometimes wild values
  task automatic send_random(int n);
    logic [15:0] c;
    logic [31:0] sp;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) c = 16'($urandom);
      else c = cur_count + 16'($signed($urandom_range(0, 400)) - 200);
      if ($urandom_range(0, 7) == 0) sp = $urandom;
      else sp = 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
      send_tick(c, sp);
    end
  endtask

  task automatic cfg_random();
    cfg_write(wsmsc_pkg::RegSlope, $urandom_range(0, 40 << 16));
    cfg_write(wsmsc_pkg::RegGain, $urandom_range(0, 50 << 16));
    cfg_write(wsmsc_pkg::RegSwHigh,
              ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 60 << 16));
    cfg_write(wsmsc_pkg::RegSwLow, $urandom_range(0, 60 << 16));
    cfg_write(wsmsc_pkg::RegAdapt, 32'($signed($urandom_range(0, 2000)) - 1000));
    cfg_write(wsmsc_pkg::RegSpc,
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 26));
    cfg_write(wsmsc_pkg::RegPeriod, $urandom_range(1, 1 << 14));
    cfg_write(wsmsc_pkg::RegRate, $urandom_range(1, 10000));
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    cur_count = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed at reset settings: wrap edges and setpoint extremes
    send_tick(16'd0, 32'sd0);
    send_tick(16'd32768, 32'sd0);
    send_tick(16'd0, 32'h7FFF_FFFF);
    send_tick(16'd65535, 32'h8000_0000);
    send_tick(16'd1, 32'h0001_0000);
    send_tick(16'd32770, 32'hFFFF_0000);
    send_tick(16'd2, 32'h0000_8000);
    send_tick(16'd2, 32'h03E8_0000);
    send_tick(16'd100, 32'hFC18_0000);
    drain();

    // extreme gains and scales
    cfg_write(wsmsc_pkg::RegSlope, 32'h7FFF_FFFF);
    cfg_write(wsmsc_pkg::RegGain, 32'h7FFF_FFFF);
    cfg_write(wsmsc_pkg::RegSwHigh, 32'h7FFF_FFFF);
    cfg_write(wsmsc_pkg::RegSwLow, 32'h7FFF_FFFF);
    cfg_write(wsmsc_pkg::RegAdapt, 32'h7FFF_FFFF);
    cfg_write(wsmsc_pkg::RegSpc, 32'hFFFF_FFFF);
    cfg_write(wsmsc_pkg::RegPeriod, 32'h7FFF_FFFF);
    cfg_write(wsmsc_pkg::RegRate, 32'd10000);
    send_tick(16'd40000, 32'h7FFF_FFFF);
    send_tick(16'd7000, 32'h8000_0000);
    send_tick(16'd7001, 32'sd0);
    drain();
    cfg_write(wsmsc_pkg::RegAdapt, 32'h8000_0000);
    send_tick(16'd60000, 32'h1234_5678);
    send_tick(16'd59000, 32'hDEAD_BEEF);
    drain();

    // no drive terms: zero command keeps the held duty
    cfg_write(wsmsc_pkg::RegSlope, 32'd0);
    cfg_write(wsmsc_pkg::RegGain, 32'd0);
    cfg_write(wsmsc_pkg::RegSwHigh, 32'd0);
    cfg_write(wsmsc_pkg::RegSwLow, 32'd0);
    cfg_write(wsmsc_pkg::RegAdapt, 32'd0);
    cfg_write(wsmsc_pkg::RegPeriod, 32'd1);
    cfg_write(wsmsc_pkg::RegRate, 32'd1);
    send_tick(16'd59000, 32'sd0);
    send_tick(16'd59000, 32'sd0);
    send_tick(16'd59000, 32'h0005_0000);
    drain();

    // random settings, random ticks, with a long output hold
    cfg_random();
    send_random(60);
    hold_req = 1'b1;
    send_random(60);
    drain();
    cfg_random();
    send_random(120);
    drain();
    cfg_random();
    quiet = 1'b1;
    send_random(120);
    drain();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire

// ===== sim.f =====
rtl/wsmsc_pkg.sv
rtl/wsmsc_if.sv
rtl/wsmsc_mul.sv
rtl/wheel_sliding_mode_speed_control.sv
rtl/wsmsc_checker.sv
dv/tb_wheel_sliding_mode_speed_control.sv
